@@ design/cbpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_pkg
// Types, widths and arithmetic helpers for the composite Bezier evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    localparam int COORD_W     = 32;
    localparam int PT_W        = COORD_W + 1;
    localparam int FRAC_W      = 16;
    localparam int T_W         = FRAC_W + 1;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int MAX_ANCHORS = 64;
    localparam int PROD_W      = PT_W + 1 + T_W + 1;
    localparam int BANK_DEPTH  = MAX_ANCHORS / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ANCHORS);
    localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << FRAC_W;
    localparam logic             MODE_WRITE = 1'b0;
    localparam logic             MODE_EVAL  = 1'b1;

    localparam logic [2:0] ADDR_ANCHOR_COUNT = 3'd0;

    // position, position plus outgoing handle, position plus incoming handle
    typedef struct packed {
        logic signed [PT_W-1:0] pos;
        logic signed [PT_W-1:0] pout;
        logic signed [PT_W-1:0] pin;
    } axis_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
    } anchor_t;

    // a + floor(((b - a) * f + half) / 2^FRAC_W)
    function automatic logic signed [PT_W-1:0] lerp(
        input logic signed [PT_W-1:0] a,
        input logic signed [PT_W-1:0] b,
        input logic [T_W-1:0]         f
    );
        logic signed [PT_W:0]     d;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] s;
        d = {b[PT_W-1], b} - {a[PT_W-1], a};
        p = PROD_W'(d) * $signed({{(PROD_W-T_W){1'b0}}, f});
        s = (p + (PROD_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        return a + s[PT_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic signed [PT_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v[PT_W-1] == v[PT_W-2])
            r = v[COORD_W-1:0];
        else if (v[PT_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ design/cbpe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ design/composite_bezier_point_eval_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// composite_bezier_point_eval_top
// Piecewise cubic Bezier point evaluator over a table of 64 anchors.
// ----------------------------------------------------------------------------
// busy is never asserted: a word can be started every cycle. A write word
// stores its anchor at the start edge and gives no result. An evaluate word
// gives its result on the result ports with done high for one cycle, after
// the bank read and the three level registers; the receiver cannot stall. Even and odd
// anchors sit in two RAM banks so both ends of a segment are read in the same
// cycle, then three pipelined de Casteljau levels each spend one multiply per lerp.
module composite_bezier_point_eval_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [cbpe_pkg::IDX_W-1:0]    anchor_index,
    input  logic signed [cbpe_pkg::COORD_W-1:0] pos_x,
    input  logic signed [cbpe_pkg::COORD_W-1:0] pos_y,
    input  logic signed [cbpe_pkg::COORD_W-1:0] out_handle_x,
    input  logic signed [cbpe_pkg::COORD_W-1:0] out_handle_y,
    input  logic signed [cbpe_pkg::COORD_W-1:0] in_handle_x,
    input  logic signed [cbpe_pkg::COORD_W-1:0] in_handle_y,
    input  logic [cbpe_pkg::T_W-1:0]      param_t,
    output logic                          done,
    output logic signed [cbpe_pkg::COORD_W-1:0] point_x,
    output logic signed [cbpe_pkg::COORD_W-1:0] point_y,
    output logic [cbpe_pkg::IDX_W-1:0]    segment_used,
    output logic                          curve_empty
);
    import cbpe_pkg::*;

    logic [CNT_W-1:0] anchor_count_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == ADDR_ANCHOR_COUNT) ? {25'd0, anchor_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            anchor_count_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_ANCHOR_COUNT)
            anchor_count_reg <= pwdata[CNT_W-1:0];
    end

    // ---------------- stage 0: segment select and table write
    logic                  accept;
    logic                  is_eval;
    logic [CNT_W-1:0]      n_cnt;
    logic [IDX_W-1:0]      n_m1;
    logic [IDX_W-1:0]      n_m2;
    logic [T_W-1:0]        t_clamped;
    logic [T_W+IDX_W-1:0]  scaled;
    logic [IDX_W-1:0]      seg_raw;
    logic [IDX_W-1:0]      seg;
    logic [T_W+IDX_W-1:0]  frac_full;
    logic [IDX_W:0]        seg_p1;
    anchor_t               wr_word;
    anchor_t               even_rd;
    anchor_t               odd_rd;

    assign accept    = start && !busy;
    assign is_eval   = accept && (mode == MODE_EVAL);
    assign n_cnt     = (anchor_count_reg > CNT_MAX) ? CNT_MAX : anchor_count_reg;
    assign n_m1      = IDX_W'(n_cnt - CNT_W'(1));
    assign n_m2      = IDX_W'(n_cnt - CNT_W'(2));
    assign t_clamped = (param_t > T_ONE) ? T_ONE : param_t;
    assign scaled    = (T_W+IDX_W)'(t_clamped) * (T_W+IDX_W)'(n_m1);
    assign seg_raw   = scaled[T_W+IDX_W-2:FRAC_W];
    assign seg       = (seg_raw > n_m2) ? n_m2 : seg_raw;
    assign frac_full = scaled - ((T_W+IDX_W)'(seg) << FRAC_W);
    assign seg_p1    = {1'b0, seg} + (IDX_W+1)'(1);

    assign wr_word.x.pos  = PT_W'(pos_x);
    assign wr_word.x.pout = PT_W'(pos_x) + PT_W'(out_handle_x);
    assign wr_word.x.pin  = PT_W'(pos_x) + PT_W'(in_handle_x);
    assign wr_word.y.pos  = PT_W'(pos_y);
    assign wr_word.y.pout = PT_W'(pos_y) + PT_W'(out_handle_y);
    assign wr_word.y.pin  = PT_W'(pos_y) + PT_W'(in_handle_y);

    cbpe_ram #(.WIDTH($bits(anchor_t)), .DEPTH(BANK_DEPTH)) u_even (
        .clk   (clk),
        .we    (accept && mode == MODE_WRITE && !anchor_index[0]),
        .waddr (anchor_index[IDX_W-1:1]),
        .wdata (wr_word),
        .raddr (seg_p1[BANK_AW:1]),
        .rdata (even_rd)
    );

    cbpe_ram #(.WIDTH($bits(anchor_t)), .DEPTH(BANK_DEPTH)) u_odd (
        .clk   (clk),
        .we    (accept && mode == MODE_WRITE && anchor_index[0]),
        .waddr (anchor_index[IDX_W-1:1]),
        .wdata (wr_word),
        .raddr (seg[BANK_AW:1]),
        .rdata (odd_rd)
    );

    // ---------------- pipeline control
    logic [2:0]           vld_reg;
    logic [IDX_W-1:0]     seg1_reg, seg2_reg, seg3_reg;
    logic [T_W-1:0]       f1_reg, f2_reg, f3_reg;
    logic                 emp1_reg, emp2_reg, emp3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], is_eval};
            done    <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        seg1_reg <= seg;
        f1_reg   <= frac_full[T_W-1:0];
        emp1_reg <= (n_cnt < CNT_W'(2));
        seg2_reg <= seg1_reg;
        f2_reg   <= f1_reg;
        emp2_reg <= emp1_reg;
        seg3_reg <= seg2_reg;
        f3_reg   <= f2_reg;
        emp3_reg <= emp2_reg;
    end

    // ---------------- stage 1: first interpolation level
    anchor_t a_ent;
    anchor_t b_ent;
    assign a_ent = seg1_reg[0] ? odd_rd : even_rd;
    assign b_ent = seg1_reg[0] ? even_rd : odd_rd;

    logic signed [PT_W-1:0] qx0_reg, qx1_reg, qx2_reg, qy0_reg, qy1_reg, qy2_reg;
    logic signed [PT_W-1:0] rx0_reg, rx1_reg, ry0_reg, ry1_reg;

    always_ff @(posedge clk)
    begin
        qx0_reg <= lerp(a_ent.x.pos,  a_ent.x.pout, f1_reg);
        qx1_reg <= lerp(a_ent.x.pout, b_ent.x.pin,  f1_reg);
        qx2_reg <= lerp(b_ent.x.pin,  b_ent.x.pos,  f1_reg);
        qy0_reg <= lerp(a_ent.y.pos,  a_ent.y.pout, f1_reg);
        qy1_reg <= lerp(a_ent.y.pout, b_ent.y.pin,  f1_reg);
        qy2_reg <= lerp(b_ent.y.pin,  b_ent.y.pos,  f1_reg);
        // stage 2
        rx0_reg <= lerp(qx0_reg, qx1_reg, f2_reg);
        rx1_reg <= lerp(qx1_reg, qx2_reg, f2_reg);
        ry0_reg <= lerp(qy0_reg, qy1_reg, f2_reg);
        ry1_reg <= lerp(qy1_reg, qy2_reg, f2_reg);
        // stage 3: final level, saturate, empty curve forces zero
        point_x      <= emp3_reg ? '0 : sat(lerp(rx0_reg, rx1_reg, f3_reg));
        point_y      <= emp3_reg ? '0 : sat(lerp(ry0_reg, ry1_reg, f3_reg));
        segment_used <= emp3_reg ? '0 : seg3_reg;
        curve_empty  <= emp3_reg;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the composite Bezier point evaluator. Anchor words
// load the table, evaluate words are scored against an in-bench fixed point
// de Casteljau predictor, over several anchor counts set through the APB port.
// ----------------------------------------------------------------------------
module tb_top;
    import cbpe_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          seg;
        logic                      empty;
    } point_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [2:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      mode = MODE_WRITE;
    logic [IDX_W-1:0]          anchor_index = '0;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [COORD_W-1:0] out_handle_x = '0;
    logic signed [COORD_W-1:0] out_handle_y = '0;
    logic signed [COORD_W-1:0] in_handle_x = '0;
    logic signed [COORD_W-1:0] in_handle_y = '0;
    logic [T_W-1:0]            param_t = '0;
    logic                      done;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [IDX_W-1:0]          segment_used;
    logic                      curve_empty;

    // predictor copy of the anchor table and the count register
    logic signed [COORD_W-1:0] tbl_px [MAX_ANCHORS];
    logic signed [COORD_W-1:0] tbl_py [MAX_ANCHORS];
    logic signed [COORD_W-1:0] tbl_ox [MAX_ANCHORS];
    logic signed [COORD_W-1:0] tbl_oy [MAX_ANCHORS];
    logic signed [COORD_W-1:0] tbl_ix [MAX_ANCHORS];
    logic signed [COORD_W-1:0] tbl_iy [MAX_ANCHORS];
    logic [CNT_W-1:0]          model_count = '0;

    point_t expected_points [$];
    int     errors = 0;
    bit     gaps_on = 1'b1;

    always #2 clk = ~clk;

    composite_bezier_point_eval_top dut (.*);

    function automatic longint lerp_q16(longint a, longint b, longint f);
        return a + (((b - a) * f + 64'sd32768) >>> FRAC_W);
    endfunction

    function automatic logic signed [COORD_W-1:0] cubic_point(longint p0, longint p1,
                                                              longint p2, longint p3,
                                                              longint f);
        longint q0, q1, q2, r0, r1, v;
        q0 = lerp_q16(p0, p1, f);
        q1 = lerp_q16(p1, p2, f);
        q2 = lerp_q16(p2, p3, f);
        r0 = lerp_q16(q0, q1, f);
        r1 = lerp_q16(q1, q2, f);
        v  = lerp_q16(r0, r1, f);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t curve_point(logic [T_W-1:0] t_in);
        point_t p;
        longint n, t, scaled, s, f;
        int a, b;
        n = (model_count > CNT_MAX) ? MAX_ANCHORS : model_count;
        p = '{x: '0, y: '0, seg: '0, empty: 1'b1};
        if (n < 2)
            return p;
        t = (t_in > T_ONE) ? T_ONE : t_in;
        scaled = t * (n - 1);
        s = scaled >>> FRAC_W;
        if (s > n - 2)
            s = n - 2;
        f = scaled - (s <<< FRAC_W);
        a = int'(s);
        b = a + 1;
        p.x = cubic_point(tbl_px[a], longint'(tbl_px[a]) + tbl_ox[a],
                          longint'(tbl_px[b]) + tbl_ix[b], tbl_px[b], f);
        p.y = cubic_point(tbl_py[a], longint'(tbl_py[a]) + tbl_oy[a],
                          longint'(tbl_py[b]) + tbl_iy[b], tbl_py[b], f);
        p.seg = s[IDX_W-1:0];
        p.empty = 1'b0;
        return p;
    endfunction

    // extremes often, so saturation and sign corners get hit
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        case ($urandom_range(0, 5))
            0: return T_ONE;
            1: return '0;
            2: return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
            default: return T_W'($urandom_range(0, T_ONE));
        endcase
    endfunction

    always @(posedge clk) begin
        point_t e;
        if (rst_n && done) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result word x=%h y=%h", point_x, point_y);
                errors++;
            end
            else begin
                e = expected_points.pop_front();
                if (point_x !== e.x) begin
                    $error("point_x expected %h actual %h", e.x, point_x);
                    errors++;
                end
                if (point_y !== e.y) begin
                    $error("point_y expected %h actual %h", e.y, point_y);
                    errors++;
                end
                if (segment_used !== e.seg) begin
                    $error("segment_used expected %0d actual %0d", e.seg, segment_used);
                    errors++;
                end
                if (curve_empty !== e.empty) begin
                    $error("curve_empty expected %b actual %b", e.empty, curve_empty);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic m, logic [IDX_W-1:0] idx,
                             logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                             logic signed [COORD_W-1:0] ox, logic signed [COORD_W-1:0] oy,
                             logic signed [COORD_W-1:0] ix, logic signed [COORD_W-1:0] iy,
                             logic [T_W-1:0] t);
        @(negedge clk);
        start        <= 1'b1;
        mode         <= m;
        anchor_index <= idx;
        pos_x        <= px;
        pos_y        <= py;
        out_handle_x <= ox;
        out_handle_y <= oy;
        in_handle_x  <= ix;
        in_handle_y  <= iy;
        param_t      <= t;
        do
            @(posedge clk);
        while (busy);
        if (m == MODE_WRITE) begin
            tbl_px[idx] = px;
            tbl_py[idx] = py;
            tbl_ox[idx] = ox;
            tbl_oy[idx] = oy;
            tbl_ix[idx] = ix;
            tbl_iy[idx] = iy;
        end
        else
            expected_points = {expected_points, curve_point(t)};
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    task automatic write_anchor(int idx);
        send_word(MODE_WRITE, IDX_W'(idx), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), T_W'($urandom));
    endtask

    task automatic eval_point(logic [T_W-1:0] t);
        send_word(MODE_EVAL, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, t);
    endtask

    // waits for the pipeline to drain, then one APB write of anchor_count
    task automatic set_anchor_count(logic [CNT_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ANCHOR_COUNT;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_count = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_empty_curve();
        eval_point(T_ONE);
        eval_point('0);
        set_anchor_count(CNT_W'(1));
        eval_point(T_ONE >> 1);
        eval_point('1);
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < MAX_ANCHORS; i++)
            write_anchor(i);
    endtask

    task automatic test_directed_extremes();
        set_anchor_count(CNT_W'(2));
        send_word(MODE_WRITE, IDX_W'(0), 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 32'sh7fffffff, 32'sh80000000, '0);
        send_word(MODE_WRITE, IDX_W'(1), 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, '1);
        eval_point('0);
        eval_point(T_ONE >> 1);
        eval_point(T_ONE);
        eval_point('1);
        eval_point(T_ONE + 1);
        set_anchor_count(CNT_MAX);
        eval_point(T_ONE);
        eval_point(T_ONE - 1);
        eval_point('0);
        // count above the table size clamps to the full table
        set_anchor_count('1);
        eval_point(T_ONE);
        eval_point(T_ONE >> 2);
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cnt, int words);
        set_anchor_count(cnt);
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(0, 3) == 0)
                write_anchor($urandom_range(0, MAX_ANCHORS - 1));
            else
                eval_point(rand_t());
        end
    endtask

    task automatic test_random_phases();
        int counts [10] = '{2, 3, 64, 0, 5, 64, 1, 100, 33, 17};
        foreach (counts[k])
            run_phase(CNT_W'(counts[k]), 75);
        for (int k = 0; k < 2; k++)
            run_phase(CNT_W'($urandom_range(2, 64)), 40);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_phase(CNT_W'(64), 90);
        run_phase(CNT_W'(4), 50);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_curve();
        test_fill_table();
        test_directed_extremes();
        test_random_phases();
        test_back_to_back();
        @(negedge clk);
        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
